>>> sv/dssa_pkg.sv
package dssa_pkg;

   // default number of memory entries
   localparam int DEPTH_DEFAULT = 16;

   // field widths
   localparam int CAP_W  = 5;
   localparam int CNT_W  = 5;
   localparam int OP_W   = 3;
   localparam int DATA_W = 32;
   localparam int ST_W   = 2;

   // packed channel widths, padded to whole bytes
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   // capacity after reset, before clamping to the depth
   localparam int CAP_RESET_RAW = 16;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUSH_ONE = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_TWO = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_ONE  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_TWO  = 3'd3;
   localparam logic [OP_W-1:0] OP_PEEK_ONE = 3'd4;
   localparam logic [OP_W-1:0] OP_PEEK_TWO = 3'd5;

   // status codes
   localparam logic [ST_W-1:0] ST_OK       = 2'd0;
   localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;

   // commands from the controller to the datapath
   typedef struct packed {
      logic accept;    // take the request item, update pointers, start the memory access
      logic load_out;  // move the finished result into the output register
   } dssa_cmd_type;

endpackage

>>> sv/dual_stack_shared_array.sv
// Two stacks in one memory of DEPTH entries. Stack one grows up from entry 0,
// stack two grows down from entry capacity-1.
// req channel: one item per operation (push, pop or peek on either stack).
// rsp channel: exactly one item per request, carrying data and status.
// csr channel: writes the capacity (0 reads as 1, anything above the depth
// as the depth); a write empties both stacks and is always ready.
// A taken request is held in the item-in-flight registers, and the synchronous
// read of the element memory lands in its read register; the result then moves
// into the output register. One item is in flight at a time: req_tready is low until it moves on.
// While rsp is stalled the result is held in the output register; one more
// request is taken and its result waits in the datapath, then req_tready
// stays low until the output register frees up.
// Reset: both stacks empty, capacity min(16, DEPTH), output not valid.
// Memory contents are not cleared; no entry is read before it is written.
module dual_stack_shared_array import dssa_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // op [2:0], value [34:3], zero pad [39:35]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // data [31:0], status [33:32], zero pad [39:34]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [CAP_W-1:0]       csr_data,
   input  logic                   csr_valid,
   output logic                   csr_ready
);

   dssa_cmd_type      cmd;
   logic [OP_W-1:0]   req_op;
   logic [DATA_W-1:0] req_value;
   logic [DATA_W-1:0] rsp_data;
   logic [ST_W-1:0]   rsp_status;
   logic              csr_write;

   // field unpacking
   assign req_op    = req_tdata[OP_W-1:0];
   assign req_value = req_tdata[OP_W+DATA_W-1:OP_W];
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   dssa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   dssa_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .op         (req_op),
      .value      (req_value),
      .csr_write  (csr_write),
      .csr_value  (csr_data),
      .out_data   (rsp_data),
      .out_status (rsp_status)
   );

   // field packing
   assign rsp_tdata = {(RSP_TDATA_W-DATA_W-ST_W)'(0), rsp_status, rsp_data};

   // one item in flight: an accepted request has closed the input by the next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while another item is in flight");

   // status is always one of the defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_status == ST_OK || rsp_status == ST_OVERFLOW
                      || rsp_status == ST_EMPTY))
      else $error("undefined status code on rsp");

   // an overflowed push carries zero data
   a_overflow_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status == ST_OVERFLOW) |-> (rsp_data == '0))
      else $error("overflow result with non-zero data");

   // a fresh result appears only after a request was taken
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result raised without an item in flight");

endmodule

>>> sv/dssa_ctrl.sv
module dssa_ctrl import dssa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output dssa_cmd_type cmd
);

   // state codes
   localparam logic S_IDLE = 1'b0;
   localparam logic S_BUSY = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic out_free;

   // handshake decode
   assign req_tready   = (state_ff == S_IDLE);
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign cmd.accept   = req_tvalid && (state_ff == S_IDLE);
   assign cmd.load_out = (state_ff == S_BUSY) && out_free;
   assign rsp_tvalid   = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.accept) begin
               state_in = S_BUSY;
            end
         end
         S_BUSY: begin
            if (cmd.load_out) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> sv/dssa_datapath.sv
module dssa_datapath import dssa_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  dssa_cmd_type      cmd,
   input  logic [OP_W-1:0]   op,
   input  logic [DATA_W-1:0] value,
   input  logic              csr_write,
   input  logic [CAP_W-1:0]  csr_value,
   output logic [DATA_W-1:0] out_data,
   output logic [ST_W-1:0]   out_status
);

   localparam int AW        = $clog2(DEPTH);
   localparam int IDX_W     = (AW > CNT_W) ? AW : CNT_W;
   localparam int CAP_MAX_I = (DEPTH < 31) ? DEPTH : 31;
   localparam int CAP_RST_I = (DEPTH < CAP_RESET_RAW) ? DEPTH : CAP_RESET_RAW;
   localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(CAP_MAX_I);
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(CAP_RST_I);

   // element memory, shared by both stacks
   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   logic [CAP_W-1:0]  capacity_ff;
   logic [CAP_W-1:0]  capacity_in;
   logic [CNT_W-1:0]  count_low_ff;
   logic [CNT_W-1:0]  count_low_in;
   logic [CNT_W-1:0]  count_high_ff;
   logic [CNT_W-1:0]  count_high_in;

   logic              pend_peek_ff;
   logic              pend_peek_in;
   logic [ST_W-1:0]   pend_status_ff;
   logic [ST_W-1:0]   pend_status_in;

   logic [DATA_W-1:0] out_data_ff;
   logic [ST_W-1:0]   out_status_ff;
   logic [DATA_W-1:0] result_data;

   logic [CNT_W:0]    used;
   logic              has_room;
   logic [CNT_W-1:0]  idx;
   logic [IDX_W-1:0]  idx_wide;
   logic [AW-1:0]     mem_addr;
   logic              mem_wr;
   logic              mem_rd;

   assign used     = {1'b0, count_low_ff} + {1'b0, count_high_ff};
   assign has_room = used < {1'b0, capacity_ff};
   assign idx_wide = IDX_W'(idx);
   assign mem_addr = idx_wide[AW-1:0];

   // operation decode: pointer moves, memory access and status
   always_comb begin
      count_low_in   = count_low_ff;
      count_high_in  = count_high_ff;
      pend_peek_in   = 1'b0;
      pend_status_in = ST_OK;
      idx            = '0;
      mem_wr         = 1'b0;
      mem_rd         = 1'b0;
      unique case (op)
         OP_PUSH_ONE: begin
            idx = count_low_ff;
            if (has_room) begin
               mem_wr       = 1'b1;
               count_low_in = count_low_ff + CNT_W'(1);
            end else begin
               pend_status_in = ST_OVERFLOW;
            end
         end
         OP_PUSH_TWO: begin
            idx = capacity_ff - count_high_ff - CNT_W'(1);
            if (has_room) begin
               mem_wr        = 1'b1;
               count_high_in = count_high_ff + CNT_W'(1);
            end else begin
               pend_status_in = ST_OVERFLOW;
            end
         end
         OP_POP_ONE: begin
            if (count_low_ff != '0) begin
               count_low_in = count_low_ff - CNT_W'(1);
            end else begin
               pend_status_in = ST_EMPTY;
            end
         end
         OP_POP_TWO: begin
            if (count_high_ff != '0) begin
               count_high_in = count_high_ff - CNT_W'(1);
            end else begin
               pend_status_in = ST_EMPTY;
            end
         end
         OP_PEEK_ONE: begin
            pend_peek_in = 1'b1;
            idx          = count_low_ff - CNT_W'(1);
            if (count_low_ff != '0) begin
               mem_rd = 1'b1;
            end else begin
               pend_status_in = ST_EMPTY;
            end
         end
         OP_PEEK_TWO: begin
            pend_peek_in = 1'b1;
            idx          = capacity_ff - count_high_ff;
            if (count_high_ff != '0) begin
               mem_rd = 1'b1;
            end else begin
               pend_status_in = ST_EMPTY;
            end
         end
         default: begin
            // unused codes leave the stacks alone
         end
      endcase
   end

   // capacity write, clamped to the usable range
   always_comb begin
      priority if (csr_value == '0) begin
         capacity_in = CAP_W'(1);
      end else if (csr_value > CAP_MAX) begin
         capacity_in = CAP_MAX;
      end else begin
         capacity_in = csr_value;
      end
   end

   // control registers; a capacity write empties both stacks
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= CAP_RESET;
         count_low_ff  <= '0;
         count_high_ff <= '0;
      end else if (csr_write) begin
         capacity_ff   <= capacity_in;
         count_low_ff  <= '0;
         count_high_ff <= '0;
      end else if (cmd.accept) begin
         count_low_ff  <= count_low_in;
         count_high_ff <= count_high_in;
      end
   end

   // memory write port
   always_ff @(posedge clock) begin
      if (cmd.accept && mem_wr) begin
         mem_ff[mem_addr] <= value;
      end
   end

   // memory read port, registered
   always_ff @(posedge clock) begin
      if (cmd.accept && mem_rd) begin
         rd_data_ff <= mem_ff[mem_addr];
      end
   end

   // item in flight
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pend_peek_ff   <= pend_peek_in;
         pend_status_ff <= pend_status_in;
      end
   end

   // result data: top element, all ones for an empty peek, else zero
   always_comb begin
      priority if (!pend_peek_ff) begin
         result_data = '0;
      end else if (pend_status_ff == ST_EMPTY) begin
         result_data = '1;
      end else begin
         result_data = rd_data_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_data_ff   <= result_data;
         out_status_ff <= pend_status_ff;
      end
   end

   assign out_data   = out_data_ff;
   assign out_status = out_status_ff;

endmodule

>>> tb/dual_stack_shared_array_test.sv
`timescale 1ns / 1ps

module dual_stack_shared_array_test;
   import dssa_pkg::*;

   // op codes the block leaves unused
   localparam logic [OP_W-1:0] OP_SPARE_SIX   = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_SEVEN = 3'd7;

   localparam int STORE_DEPTH = DEPTH_DEFAULT;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic [ST_W-1:0]   status;
   } stack_answer_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [CAP_W-1:0]       csr_data = '0;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;

   // idle chances in percent, and the long receiver hold-off
   int unsigned send_idle_pct = 36;
   int unsigned recv_idle_pct = 71;
   int unsigned hold_off_request = 0;
   int unsigned hold_off_left = 0;

   int unsigned      mismatch_count = 0;
   stack_answer_type awaited_answers[$];

   // shadow of the two stacks
   logic [DATA_W-1:0] shadow_store[STORE_DEPTH];
   int unsigned       shadow_low = 0;
   int unsigned       shadow_high = 0;
   int unsigned       shadow_capacity = (CAP_RESET_RAW > STORE_DEPTH) ? STORE_DEPTH
                                                                       : CAP_RESET_RAW;

   dual_stack_shared_array dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // apply one operation to the shadow stacks and work out its answer
   function automatic stack_answer_type stack_step(input logic [OP_W-1:0] op,
                                                   input logic [DATA_W-1:0] value);
      stack_answer_type ans;
      int unsigned      slot;
      ans.data   = '0;
      ans.status = ST_OK;
      case (op)
         OP_PUSH_ONE, OP_PUSH_TWO: begin
            if (shadow_low + shadow_high >= shadow_capacity) begin
               ans.status = ST_OVERFLOW;
            end else if (op == OP_PUSH_ONE) begin
               shadow_store[shadow_low] = value;
               shadow_low++;
            end else begin
               slot = shadow_capacity - shadow_high - 1;
               shadow_store[slot] = value;
               shadow_high++;
            end
         end
         OP_POP_ONE: begin
            if (shadow_low != 0) shadow_low--;
            else ans.status = ST_EMPTY;
         end
         OP_POP_TWO: begin
            if (shadow_high != 0) shadow_high--;
            else ans.status = ST_EMPTY;
         end
         OP_PEEK_ONE: begin
            if (shadow_low != 0) begin
               ans.data = shadow_store[shadow_low - 1];
            end else begin
               ans.data   = '1;
               ans.status = ST_EMPTY;
            end
         end
         OP_PEEK_TWO: begin
            if (shadow_high != 0) begin
               ans.data = shadow_store[shadow_capacity - shadow_high];
            end else begin
               ans.data   = '1;
               ans.status = ST_EMPTY;
            end
         end
         default: begin
         end
      endcase
      return ans;
   endfunction

   // watch all three channels at the rising edge
   always @(posedge clock) begin
      stack_answer_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_answers.size() == 0) begin
               report_mismatch($sformatf("unexpected item %h", rsp_tdata));
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_tdata[DATA_W-1:0] !== want.data)
                  report_mismatch($sformatf("data %h, wanted %h",
                                            rsp_tdata[DATA_W-1:0], want.data));
               if (rsp_tdata[DATA_W+ST_W-1:DATA_W] !== want.status)
                  report_mismatch($sformatf("status %0d, wanted %0d",
                                            rsp_tdata[DATA_W+ST_W-1:DATA_W], want.status));
            end
         end
         if (req_tvalid && req_tready)
            awaited_answers.push_back(stack_step(req_tdata[OP_W-1:0],
                                                 req_tdata[OP_W+DATA_W-1:OP_W]));
         if (csr_valid && csr_ready) begin
            if (csr_data == 0) shadow_capacity = 1;
            else if (csr_data > STORE_DEPTH) shadow_capacity = STORE_DEPTH;
            else shadow_capacity = csr_data;
            shadow_low  = 0;
            shadow_high = 0;
         end
      end
   end

   // receiver side: random stalls, or a long hold-off when asked
   always @(negedge clock) begin
      if (hold_off_left == 0 && hold_off_request != 0) begin
         hold_off_left    = hold_off_request;
         hold_off_request = 0;
      end
      if (hold_off_left != 0) begin
         rsp_tready <= 1'b0;
         hold_off_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // offer one item; valid stays high on return so items can go back to back
   task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= {{(REQ_TDATA_W-OP_W-DATA_W){1'b0}}, value, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // stop offering and let every outstanding item come back
   task automatic wait_until_idle;
      req_tvalid <= 1'b0;
      while (awaited_answers.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      wait_until_idle();
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [DATA_W-1:0] pick_value;
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '1;
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   // mostly pushes or mostly pops and peeks, with the odd spare code
   function automatic logic [OP_W-1:0] pick_op(input int unsigned push_pct,
                                               input int unsigned one_pct);
      int unsigned roll;
      logic        side_one;
      roll     = $urandom_range(99);
      side_one = ($urandom_range(99) < one_pct);
      if (roll < 3) return $urandom_range(1) ? OP_SPARE_SIX : OP_SPARE_SEVEN;
      if (roll < 3 + push_pct) return side_one ? OP_PUSH_ONE : OP_PUSH_TWO;
      if ($urandom_range(1)) return side_one ? OP_POP_ONE : OP_POP_TWO;
      return side_one ? OP_PEEK_ONE : OP_PEEK_TWO;
   endfunction

   // empty stacks, extreme values, every op, spare codes, at reset capacity
   task automatic test_basic_ops;
      send_item(OP_PEEK_ONE, 32'h1234_5678);
      send_item(OP_PEEK_TWO, '1);
      send_item(OP_POP_ONE, '0);
      send_item(OP_POP_TWO, 32'h8000_0000);
      send_item(OP_PUSH_ONE, 32'h7fff_ffff);
      send_item(OP_PUSH_TWO, 32'h8000_0000);
      send_item(OP_PEEK_ONE, '0);
      send_item(OP_PEEK_TWO, '0);
      send_item(OP_PUSH_ONE, '1);
      send_item(OP_PUSH_TWO, '0);
      send_item(OP_PEEK_ONE, '0);
      send_item(OP_PEEK_TWO, '0);
      send_item(OP_POP_ONE, '1);
      send_item(OP_PEEK_ONE, '0);
      send_item(OP_POP_TWO, '0);
      send_item(OP_PEEK_TWO, '0);
      send_item(OP_SPARE_SIX, 32'haaaa_5555);
      send_item(OP_SPARE_SEVEN, 32'h5555_aaaa);
      send_item(OP_POP_ONE, '0);
      send_item(OP_POP_TWO, '0);
      send_item(OP_PEEK_ONE, '0);
   endtask

   // a zero capacity reads as one entry: stacks meet at once
   task automatic test_smallest_capacity;
      write_capacity('0);
      send_item(OP_PUSH_TWO, 32'hdead_beef);
      send_item(OP_PUSH_ONE, 32'h0bad_f00d);
      send_item(OP_PEEK_TWO, '0);
      send_item(OP_POP_TWO, '0);
      send_item(OP_PUSH_ONE, 32'hc001_d00d);
      send_item(OP_PUSH_TWO, 32'h1);
      send_item(OP_PEEK_ONE, '0);
      send_item(OP_PEEK_TWO, '0);
   endtask

   // random bursts under a range of capacities with one idling pattern
   task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct);
      logic [CAP_W-1:0] cap_plan[8];
      int unsigned      push_pct;
      int unsigned      one_pct;
      int unsigned      burst_left;
      cap_plan = '{5'd0, 5'd1, 5'd2, 5'd5, 5'd16, 5'd17, 5'd31, 5'd0};
      cap_plan[7] = CAP_W'($urandom);
      wait_until_idle();
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      foreach (cap_plan[c]) begin
         write_capacity(cap_plan[c]);
         burst_left = 0;
         push_pct   = 0;
         one_pct    = 50;
         repeat (70) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(3, 20);
               push_pct   = $urandom_range(1) ? 70 : 22;
               one_pct    = $urandom_range(1) ? 50 : $urandom_range(10, 90);
            end
            send_item(pick_op(push_pct, one_pct), pick_value());
            burst_left--;
         end
      end
   endtask

   // receiver holds off while items keep coming, so the input has to stall
   task automatic test_output_hold_off;
      wait_until_idle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_capacity(5'd16);
      hold_off_request = 300;
      repeat (10) send_item(OP_PUSH_ONE, $urandom);
      repeat (8) send_item(OP_PUSH_TWO, $urandom);
      repeat (6) send_item(pick_op(10, 50), $urandom);
   endtask

   initial begin
      int unsigned drain_cycles;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_basic_ops();
      test_smallest_capacity();
      test_random_traffic(36, 71);
      test_random_traffic(71, 36);
      test_random_traffic(0, 0);
      test_output_hold_off();

      // drain with a bound, then give stray items time to show
      req_tvalid <= 1'b0;
      drain_cycles = 0;
      while (awaited_answers.size() != 0 && drain_cycles < 2000) begin
         @(negedge clock);
         drain_cycles++;
      end
      if (awaited_answers.size() != 0)
         report_mismatch($sformatf("%0d items never came", awaited_answers.size()));
      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // overall time limit
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
